// ----- hw/rtl/yob_pkg.sv -----
// Package: types, codes and sizes of the YUV 4:2:0 overlay alpha blender.
`default_nettype none
package yob_pkg;

  localparam int MAX_OVERLAY_WIDTH  = 256;
  localparam int MAX_OVERLAY_HEIGHT = 256;
  localparam int CH_W = MAX_OVERLAY_WIDTH / 2;
  localparam int CH_H = MAX_OVERLAY_HEIGHT / 2;

  localparam int LUMA_DEPTH = MAX_OVERLAY_WIDTH * MAX_OVERLAY_HEIGHT;
  localparam int CH_DEPTH   = CH_W * CH_H;
  localparam int LUMA_AW    = (LUMA_DEPTH > 1) ? $clog2(LUMA_DEPTH) : 1;
  localparam int CH_AW      = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_BLEND = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERLAY_WIDTH  = 3'd0,
    CFG_OVERLAY_HEIGHT = 3'd1,
    CFG_POS_X          = 3'd2,
    CFG_POS_Y          = 3'd3,
    CFG_FRAME_WIDTH    = 3'd4,
    CFG_FRAME_HEIGHT   = 3'd5,
    CFG_OPACITY_Q8     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        operation;
    logic [1:0]  plane;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    logic [7:0]  sample_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic       covered;
    logic       out_of_frame;
  } out_item_t;

endpackage
`default_nettype wire

// ----- hw/rtl/yob_if.sv -----
// Interfaces: input and result streams with valid/ready handshake.
`default_nettype none
interface yob_in_if;
  import yob_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface yob_out_if;
  import yob_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/yuv420_overlay_alpha_blend.sv -----
// Top level: YUV 4:2:0 overlay store and per-sample alpha blender.
//
//  Port    Dir  Kind        Contents
//  in_i    in   valid/ready operation, plane, coord_x, coord_y, sample_value
//  out_o   out  valid/ready result_value, covered, out_of_frame
//  cfg_*   in   write only  overlay size/position, frame size, opacity
//
// One item per cycle sustained while the output is taken. A blend item reads
// the overlay memory at accept into a read register as it enters stage 1; its
// result is registered when stage 1 advances. Loads write the memory at accept,
// no result. Reset empties the pipeline and sets config defaults; overlay
// memory is not cleared. A stalled output holds the pipeline; input ready drops
// only when both stages are full and the output is not taken.
`default_nettype none
module yuv420_overlay_alpha_blend (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  yob_in_if.sink                              in_i,
  yob_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [yob_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [yob_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import yob_pkg::*;

  localparam logic [12:0] MAXW = 13'(MAX_OVERLAY_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_OVERLAY_HEIGHT);
  localparam logic [12:0] CHW  = 13'(CH_W);
  localparam logic [12:0] CHH  = 13'(CH_H);

  // config registers
  logic [8:0]  ovl_w_q, ovl_h_q, opacity_q;
  logic [11:0] pos_x_q, pos_y_q;
  logic [12:0] frm_w_q, frm_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovl_w_q   <= '0;
      ovl_h_q   <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      frm_w_q   <= 13'd1920;
      frm_h_q   <= 13'd1080;
      opacity_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OVERLAY_WIDTH:  ovl_w_q   <= cfg_wdata_i[8:0];
        CFG_OVERLAY_HEIGHT: ovl_h_q   <= cfg_wdata_i[8:0];
        CFG_POS_X:          pos_x_q   <= cfg_wdata_i[11:0];
        CFG_POS_Y:          pos_y_q   <= cfg_wdata_i[11:0];
        CFG_FRAME_WIDTH:    frm_w_q   <= cfg_wdata_i;
        CFG_FRAME_HEIGHT:   frm_h_q   <= cfg_wdata_i;
        CFG_OPACITY_Q8:     opacity_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_fire;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;

  // stage 0: geometry per plane
  in_item_t    it;
  logic        is_blend, is_luma, is_chroma;
  logic [12:0] ow, oh, fw, fh;
  logic [11:0] px, py, dx, dy, ax, ay;
  logic        oof, cov;

  assign it        = in_i.data;
  assign is_blend  = (op_e'(it.operation) == OP_BLEND);
  assign is_luma   = (it.plane == PLANE_Y);
  assign is_chroma = (it.plane == PLANE_U) || (it.plane == PLANE_V);

  always_comb begin
    ow = ({4'd0, ovl_w_q} > MAXW) ? MAXW : {4'd0, ovl_w_q};
    oh = ({4'd0, ovl_h_q} > MAXH) ? MAXH : {4'd0, ovl_h_q};
    fw = frm_w_q;
    fh = frm_h_q;
    px = pos_x_q;
    py = pos_y_q;
    if (!is_luma) begin
      ow = ow >> 1;
      oh = oh >> 1;
      fw = fw >> 1;
      fh = fh >> 1;
      px = px >> 1;
      py = py >> 1;
    end
    dx  = it.coord_x - px;
    dy  = it.coord_y - py;
    oof = !(is_luma || is_chroma) || ({1'b0, it.coord_x} >= fw) ||
          ({1'b0, it.coord_y} >= fh);
    cov = !oof && (it.coord_x >= px) && (it.coord_y >= py) &&
          ({1'b0, dx} < ow) && ({1'b0, dy} < oh);
    ax  = is_blend ? dx : it.coord_x;
    ay  = is_blend ? dy : it.coord_y;
  end

  logic               luma_we, ch_we, luma_re, ch_re;
  logic [LUMA_AW-1:0] luma_addr;
  logic [CH_AW:0]     ch_addr;

  // chroma: V entries sit in the upper half of the shared array
  assign luma_addr = LUMA_AW'(32'(ay) * MAX_OVERLAY_WIDTH + 32'(ax));
  assign ch_addr   = {(it.plane == PLANE_V), CH_AW'(32'(ay) * CH_W + 32'(ax))};

  assign luma_we = in_fire && !is_blend && is_luma &&
                   ({1'b0, it.coord_x} < MAXW) && ({1'b0, it.coord_y} < MAXH);
  assign ch_we   = in_fire && !is_blend && is_chroma &&
                   ({1'b0, it.coord_x} < CHW) && ({1'b0, it.coord_y} < CHH);
  assign luma_re = in_fire && is_blend && cov && is_luma;
  assign ch_re   = in_fire && is_blend && cov && is_chroma;

  // overlay memories with registered read; read data holds while stalled
  logic [7:0] luma_mem [LUMA_DEPTH];
  logic [7:0] ch_mem [2*CH_DEPTH];
  logic [7:0] luma_rd_q, ch_rd_q;

  always_ff @(posedge clk_i) begin
    if (luma_we) luma_mem[luma_addr] <= it.sample_value;
    if (luma_re) luma_rd_q <= luma_mem[luma_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) ch_mem[ch_addr] <= it.sample_value;
    if (ch_re) ch_rd_q <= ch_mem[ch_addr];
  end

  // stage 1: memory read in flight
  logic [7:0] s1_sample_q;
  logic [1:0] s1_plane_q;
  logic       s1_cov_q, s1_oof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= is_blend;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_blend) begin
      s1_sample_q <= it.sample_value;
      s1_plane_q  <= it.plane;
      s1_cov_q    <= cov;
      s1_oof_q    <= oof;
    end
  end

  // blend
  logic [7:0]  ov;
  logic [8:0]  alpha;
  logic        alpha_full;
  logic [16:0] mix;
  logic [7:0]  blend_val;

  assign ov = (s1_plane_q == PLANE_Y) ? luma_rd_q : ch_rd_q;

  assign alpha_full = opacity_q[8];
  assign alpha      = opacity_q;
  assign mix        = 17'(s1_sample_q * (9'd256 - alpha)) + 17'(ov * alpha);
  assign blend_val  = !s1_cov_q ? s1_sample_q : (alpha_full ? ov : mix[15:8]);

  // output register
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.result_value <= blend_val;
      out_q.covered      <= s1_cov_q;
      out_q.out_of_frame <= s1_oof_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // checks
  a_cov_excl_oof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.covered && out_q.out_of_frame))
    else $error("covered and out_of_frame both set");

  a_blend_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_blend |=> s1_valid_q)
    else $error("accepted blend item lost");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !is_blend && !s1_valid_q |=> !s1_valid_q)
    else $error("load item produced a result");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_sample_q))
    else $error("stalled stage 1 item changed");

  a_mem_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (luma_we || ch_we) |-> !(luma_re || ch_re))
    else $error("overlay write and read in one cycle");

endmodule
`default_nettype wire

// ----- tb/tb_yuv420_overlay_alpha_blend.sv -----
// Testbench: YUV 4:2:0 overlay alpha blender checked against an in-bench predictor.
module tb_yuv420_overlay_alpha_blend;
  import yob_pkg::*;

  localparam logic [1:0] PLANE_NONE = 2'd3;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 172;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  yob_in_if in_if ();
  yob_out_if out_if ();

  yuv420_overlay_alpha_blend i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow registers
  logic [8:0] ovl_w;
  logic [8:0] ovl_h;
  logic [11:0] pos_x_r;
  logic [11:0] pos_y_r;
  logic [12:0] frm_w;
  logic [12:0] frm_h;
  logic [8:0] alpha_q8;

  logic [7:0] ovl_store [3][LUMA_DEPTH];
  bit loaded [3][LUMA_DEPTH];

  in_item_t sample_q[$];
  out_item_t blend_exp_q[$];
  out_item_t blend_due;
  int queued_n;
  int accepted_n;
  int mismatches;
  int phase_end;
  bit no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("yuv420_overlay_alpha_blend: mismatch");
    $finish;
  end

  function automatic bit in_store(logic [1:0] pl, int x, int y);
    case (pl)
      PLANE_Y: return x < MAX_OVERLAY_WIDTH && y < MAX_OVERLAY_HEIGHT;
      PLANE_U, PLANE_V: return x < CH_W && y < CH_H;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int store_index(logic [1:0] pl, int x, int y);
    return (pl == PLANE_Y) ? y * MAX_OVERLAY_WIDTH + x : y * CH_W + x;
  endfunction

  // where a frame sample lands relative to the frame and the placed overlay
  function automatic void locate(input logic [1:0] pl, input int x, input int y,
                                 output bit oof, output bit hit,
                                 output int ox, output int oy);
    int ow, oh, fw, fh, px, py;
    ow = (ovl_w > MAX_OVERLAY_WIDTH) ? MAX_OVERLAY_WIDTH : ovl_w;
    oh = (ovl_h > MAX_OVERLAY_HEIGHT) ? MAX_OVERLAY_HEIGHT : ovl_h;
    fw = frm_w;
    fh = frm_h;
    px = pos_x_r;
    py = pos_y_r;
    if (pl != PLANE_Y) begin
      ow /= 2; oh /= 2; fw /= 2; fh /= 2; px /= 2; py /= 2;
    end
    oof = 1'b0;
    hit = 1'b0;
    ox = x - px;
    oy = y - py;
    if (pl == PLANE_NONE || x >= fw || y >= fh) begin
      oof = 1'b1;
    end else if (x >= px && y >= py && ox < ow && oy < oh) begin
      hit = 1'b1;
    end
  endfunction

  function automatic void apply_item(in_item_t it);
    out_item_t r;
    bit oof, hit;
    int ox, oy, ov, a;
    if (it.operation == OP_LOAD) begin
      if (in_store(it.plane, it.coord_x, it.coord_y))
        ovl_store[it.plane][store_index(it.plane, it.coord_x, it.coord_y)] = it.sample_value;
    end else begin
      locate(it.plane, it.coord_x, it.coord_y, oof, hit, ox, oy);
      r.result_value = it.sample_value;
      r.covered = 1'b0;
      r.out_of_frame = oof;
      if (hit) begin
        ov = ovl_store[it.plane][store_index(it.plane, ox, oy)];
        a = (alpha_q8 > 256) ? 256 : alpha_q8;
        if (a == 256)
          r.result_value = 8'(ov);
        else
          r.result_value = 8'((int'(it.sample_value) * (256 - a) + ov * a) >> 8);
        r.covered = 1'b1;
      end
      blend_exp_q.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic queue_item(op_e op, logic [1:0] pl, int x, int y, int s);
    in_item_t it;
    it.operation = op;
    it.plane = pl;
    it.coord_x = 12'(x);
    it.coord_y = 12'(y);
    it.sample_value = 8'(s);
    if (op == OP_LOAD && in_store(pl, it.coord_x, it.coord_y))
      loaded[pl][store_index(pl, it.coord_x, it.coord_y)] = 1'b1;
    sample_q.push_back(it);
    queued_n++;
  endtask

  // a covered sample whose overlay entry is still blank gets a load first
  task automatic queue_blend(logic [1:0] pl, int x, int y, int s);
    bit oof, hit;
    int ox, oy;
    x &= 'hFFF;
    y &= 'hFFF;
    locate(pl, x, y, oof, hit, ox, oy);
    if (hit && !loaded[pl][store_index(pl, ox, oy)])
      queue_item(OP_LOAD, pl, ox, oy, $urandom_range(255));
    queue_item(OP_BLEND, pl, x, y, s);
  endtask

  task automatic queue_random_item();
    int r, x, y, lim, sh, owp, ohp;
    logic [1:0] pl;
    r = $urandom_range(99);
    pl = 2'($urandom_range(2));
    if (r < 22) begin
      if ($urandom_range(9) == 0) begin
        pl = 2'($urandom_range(3));
        x = $urandom_range(4095);
        y = $urandom_range(4095);
      end else begin
        lim = (pl == PLANE_Y) ? MAX_OVERLAY_WIDTH - 1 : CH_W - 1;
        x = $urandom_range(lim);
        y = $urandom_range(lim);
      end
      queue_item(OP_LOAD, pl, x, y, $urandom_range(255));
    end else if (r < 88) begin
      sh = (pl != PLANE_Y);
      owp = ((ovl_w > MAX_OVERLAY_WIDTH) ? MAX_OVERLAY_WIDTH : ovl_w) >> sh;
      ohp = ((ovl_h > MAX_OVERLAY_HEIGHT) ? MAX_OVERLAY_HEIGHT : ovl_h) >> sh;
      x = (pos_x_r >> sh) - 1 + $urandom_range(owp + 1);
      y = (pos_y_r >> sh) - 1 + $urandom_range(ohp + 1);
      queue_blend(pl, x, y, $urandom_range(255));
    end else begin
      queue_blend(2'($urandom_range(3)), $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(255));
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    case (idx)
      CFG_OVERLAY_WIDTH:  ovl_w = 9'(val);
      CFG_OVERLAY_HEIGHT: ovl_h = 9'(val);
      CFG_POS_X:          pos_x_r = 12'(val);
      CFG_POS_Y:          pos_y_r = 12'(val);
      CFG_FRAME_WIDTH:    frm_w = 13'(val);
      CFG_FRAME_HEIGHT:   frm_h = 13'(val);
      CFG_OPACITY_Q8:     alpha_q8 = 9'(val);
      default: ;
    endcase
  endtask

  task automatic program_setup(int ow, int oh, int px, int py, int fw, int fh, int a);
    write_reg(CFG_OVERLAY_WIDTH, ow);
    write_reg(CFG_OVERLAY_HEIGHT, oh);
    write_reg(CFG_POS_X, px);
    write_reg(CFG_POS_Y, py);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_OPACITY_Q8, a);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_setup(int phase);
    int ow, oh, px, py, fw, fh, a;
    case ($urandom_range(9))
      0: ow = 0;
      1: ow = 1;
      2: ow = MAX_OVERLAY_WIDTH;
      3: ow = $urandom_range(257, 511);
      default: ow = $urandom_range(2, 64);
    endcase
    case ($urandom_range(9))
      0: oh = 0;
      1: oh = 1;
      2: oh = MAX_OVERLAY_HEIGHT;
      3: oh = $urandom_range(257, 511);
      default: oh = $urandom_range(2, 64);
    endcase
    case ($urandom_range(3))
      0: px = 0;
      1: px = 4095;
      2: px = $urandom_range(4095);
      default: px = $urandom_range(40);
    endcase
    case ($urandom_range(3))
      0: py = 0;
      1: py = 4095;
      2: py = $urandom_range(4095);
      default: py = $urandom_range(40);
    endcase
    case ($urandom_range(7))
      0: fw = $urandom_range(8191);
      1: fw = 8191;
      default: fw = px + $urandom_range(ow + 16);
    endcase
    case ($urandom_range(7))
      0: fh = $urandom_range(8191);
      1: fh = 4096;
      default: fh = py + $urandom_range(oh + 16);
    endcase
    case ($urandom_range(7))
      0: a = 0;
      1: a = 256;
      2: a = $urandom_range(257, 511);
      3: a = 1;
      4: a = 255;
      default: a = $urandom_range(256);
    endcase
    case (phase)
      0: program_setup(256, 256, 0, 0, 4096, 4096, 0);
      1: program_setup(511, 511, 4095, 4095, 8191, 8191, 511);
      2: program_setup(1, 1, 1, 1, 1, 1, 256);
      default: program_setup(ow, oh, px, py, fw & 'h1FFF, fh & 'h1FFF, a);
    endcase
  endtask

  task automatic wait_idle();
    while (accepted_n != queued_n || blend_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_item(in_if.data);
        accepted_n++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (sample_q.size() != 0 && (no_gaps || $urandom_range(99) >= 13)) begin
          in_if.valid <= 1'b1;
          in_if.data <= sample_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (blend_exp_q.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          blend_due = blend_exp_q.pop_front();
          if (out_if.data.result_value !== blend_due.result_value)
            report_mismatch($sformatf("result_value got %0d want %0d",
                                      out_if.data.result_value, blend_due.result_value));
          if (out_if.data.covered !== blend_due.covered)
            report_mismatch($sformatf("covered got %0b want %0b",
                                      out_if.data.covered, blend_due.covered));
          if (out_if.data.out_of_frame !== blend_due.out_of_frame)
            report_mismatch($sformatf("out_of_frame got %0b want %0b",
                                      out_if.data.out_of_frame, blend_due.out_of_frame));
        end
      end
      out_if.ready <= no_gaps || ($urandom_range(99) >= 13);
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OVERLAY_WIDTH;
    cfg_wdata_i = '0;
    ovl_w = '0;
    ovl_h = '0;
    pos_x_r = '0;
    pos_y_r = '0;
    frm_w = 13'd1920;
    frm_h = 13'd1080;
    alpha_q8 = 9'd256;
    queued_n = 0;
    accepted_n = 0;
    mismatches = 0;
    phase_end = 0;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: no overlay, frame edges, loads at and beyond the store edges, missing plane
    queue_blend(PLANE_Y, 0, 0, 0);
    queue_blend(PLANE_Y, 1919, 1079, 255);
    queue_blend(PLANE_Y, 1920, 0, 17);
    queue_blend(PLANE_Y, 0, 1080, 34);
    queue_blend(PLANE_U, 959, 539, 200);
    queue_blend(PLANE_U, 960, 0, 51);
    queue_blend(PLANE_V, 0, 540, 68);
    queue_blend(PLANE_NONE, 0, 0, 170);
    queue_blend(PLANE_NONE, 4095, 4095, 85);
    queue_item(OP_LOAD, PLANE_Y, 255, 255, 0);
    queue_item(OP_LOAD, PLANE_Y, 256, 0, 255);
    queue_item(OP_LOAD, PLANE_U, 127, 127, 255);
    queue_item(OP_LOAD, PLANE_V, 128, 0, 9);
    queue_item(OP_LOAD, PLANE_NONE, 0, 0, 9);
    queue_item(OP_LOAD, PLANE_Y, 4095, 4095, 9);
    wait_idle();

    // small overlay at odd position: corners inside and just outside, chroma halving
    program_setup(8, 6, 3, 5, 16, 12, 128);
    queue_blend(PLANE_Y, 3, 5, 0);
    queue_blend(PLANE_Y, 10, 10, 255);
    queue_blend(PLANE_Y, 2, 5, 255);
    queue_blend(PLANE_Y, 11, 5, 0);
    queue_blend(PLANE_Y, 3, 11, 100);
    queue_blend(PLANE_U, 1, 2, 255);
    queue_blend(PLANE_U, 4, 4, 0);
    queue_blend(PLANE_U, 5, 2, 77);
    queue_blend(PLANE_V, 1, 2, 128);
    queue_blend(PLANE_Y, 15, 11, 66);
    queue_blend(PLANE_Y, 16, 0, 66);
    queue_blend(PLANE_U, 8, 0, 66);
    wait_idle();

    // loads queued ahead of covered blends count toward each phase
    for (int p = 0; p < N_PHASES; p++) begin
      pick_setup(p);
      no_gaps = (p == 4);
      phase_end = queued_n + PHASE_ITEMS;
      while (queued_n < phase_end) queue_random_item();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("yuv420_overlay_alpha_blend: match");
    end else begin
      $display("yuv420_overlay_alpha_blend: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/yob_pkg.sv
hw/rtl/yob_if.sv
hw/rtl/yuv420_overlay_alpha_blend.sv
tb/tb_yuv420_overlay_alpha_blend.sv
